FILE: rtl/tle_pkg.sv
// Terminal line editor: shared package.
// Result word type, result kind codes and the character codes the editor decodes.
// No dependencies.
`default_nettype none

package tle_pkg;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_CMD     = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_PROMPT  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] len;
    logic       last;
  } tle_word_t;

endpackage

`default_nettype wire

FILE: rtl/tle_if.sv
// Terminal line editor: channel interfaces.
// Received-byte channel and result channel, valid/ready handshake.
// No dependencies.
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [4:0] line_length;
  logic       last_of_run;

  modport source (output valid, output out_kind, output out_byte, output line_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input line_length,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/tle_out_buf.sv
// Terminal line editor: one-word output register stage.
// Holds a result word until taken; takes the next word in the cycle the old one leaves.
// Depends on tle_pkg.
`default_nettype none

module tle_out_buf
  import tle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire tle_word_t push_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tle_word_t      out_word
);

  logic      valid_r, valid_nxt;
  tle_word_t word_r;
  logic      load;

  assign push_ready = !valid_r || out_ready;
  assign load       = push_valid && push_ready;
  assign valid_nxt  = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= push_word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

FILE: rtl/terminal_line_editor_unit.sv
// Terminal line editor: top level, line store and sequencer.
// Depends on tle_pkg, tle_if (tle_in_if, tle_out_if) and tle_out_buf.
// Result words pass the sequencer state register, then the output register stage.
// Bytes are taken only in idle; a printable byte gives one word, a backspace three,
// a carriage return a newline, one word per stored byte (one store read each) and a
// prompt; ignored bytes none. Reset clears fill count and state; no store sweep.
`default_nettype none

module terminal_line_editor_unit
  import tle_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tle_in_if.sink    in_ch,
  tle_out_if.source out_ch
);

  localparam int CW = $clog2(BUFFER_BYTES);
  localparam logic [CW:0] FILL_MAX = (CW + 1)'(BUFFER_BYTES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ECHO   = 3'd1;
  localparam logic [2:0] ST_BS     = 3'd2;
  localparam logic [2:0] ST_NL     = 3'd3;
  localparam logic [2:0] ST_CMD    = 3'd4;
  localparam logic [2:0] ST_PROMPT = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [7:0]    cur_r;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_data_r;
  logic          wr_en, rd_en;
  logic [CW-1:0] rd_addr;

  logic          accept;
  logic [7:0]    c;
  logic          push, push_ready;
  tle_word_t     word, ob_word;
  logic [CW+4:0] fill_ext;
  logic [CW:0]   idx_inc;

  assign c        = in_ch.rx_byte;
  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign fill_ext = {5'b0, fill_r};
  assign idx_inc  = {1'b0, idx_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    push      = 1'b0;
    word      = '{kind: KIND_ECHO, data: 8'h00, len: 5'd0, last: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (c == CH_BS && fill_r != '0) begin
            fill_nxt  = fill_r - 1'b1;
            step_nxt  = 2'd0;
            state_nxt = ST_BS;
          end else if (c == CH_CR) begin
            state_nxt = ST_NL;
          end else if (c inside {[CH_SPACE:CH_TILDE]}) begin
            if ({1'b0, fill_r} < FILL_MAX) begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end else begin
              fill_nxt = '0;
            end
            state_nxt = ST_ECHO;
          end
        end
      end
      ST_ECHO: begin
        push = 1'b1;
        word = '{kind: KIND_ECHO, data: cur_r, len: 5'd0, last: 1'b1};
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BS: begin
        push = 1'b1;
        word = '{kind: KIND_ECHO, data: (step_r == 2'd1) ? CH_SPACE : CH_BS,
                 len: 5'd0, last: (step_r == 2'd2)};
        if (push_ready) begin
          step_nxt = step_r + 1'b1;
          if (step_r == 2'd2) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NL: begin
        push = 1'b1;
        word = '{kind: KIND_NEWLINE, data: 8'h00, len: 5'd0, last: 1'b0};
        if (push_ready) begin
          if (fill_r != '0) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_CMD;
          end else begin
            state_nxt = ST_PROMPT;
          end
        end
      end
      ST_CMD: begin
        push = 1'b1;
        word = '{kind: KIND_CMD, data: rd_data_r, len: fill_ext[4:0], last: 1'b0};
        if (push_ready) begin
          if (idx_inc < {1'b0, fill_r}) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[CW-1:0];
            idx_nxt = idx_inc[CW-1:0];
          end else begin
            state_nxt = ST_PROMPT;
          end
        end
      end
      ST_PROMPT: begin
        push = 1'b1;
        word = '{kind: KIND_PROMPT, data: 8'h00, len: 5'd0, last: 1'b1};
        if (push_ready) begin
          fill_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r] <= c;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  tle_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push),
    .push_ready (push_ready),
    .push_word  (word),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (ob_word)
  );

  assign out_ch.out_kind    = ob_word.kind;
  assign out_ch.out_byte    = ob_word.data;
  assign out_ch.line_length = ob_word.len;
  assign out_ch.last_of_run = ob_word.last;

  a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= FILL_MAX)
    else $error("fill count beyond line limit");

  a_cmd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMD) |-> (idx_r < fill_r))
    else $error("replay index outside the stored line");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_ready && word.last) |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after final word");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_IDLE) && !rd_en)
    else $error("store write outside idle");

endmodule

`default_nettype wire
